// ----- design/wad_pkg.sv -----
// Shared types and constants for the window average and dispersion block.
package wad_pkg;

	// Field widths
	localparam int SAMPLE_W = 12;
	localparam int SPREAD_W = 24;
	localparam int COUNT_W  = 6;
	localparam int SUM_W    = 18;	// up to 63 samples of 12 bits
	localparam int ACC_W    = 30;	// up to 63 squares of 12 bits
	localparam int MUL_A_W  = 24;
	localparam int MUL_B_W  = 12;

	// Divider: two quotient bits per cycle
	localparam int DIV_W    = 32;
	localparam int REM_W    = 7;
	localparam int DIV_RADIX_STEPS = 2;
	localparam int DCNT_W   = 4;
	localparam logic [DCNT_W-1:0] MEAN_DIV_CYCLES   = 4'd9;	// 18 dividend bits
	localparam logic [DCNT_W-1:0] SPREAD_DIV_CYCLES = 4'd15;	// 30 dividend bits

	// Spread while too few samples are held
	localparam logic [SPREAD_W-1:0] SPREAD_FEW      = 24'd1000;
	localparam logic [COUNT_W-1:0]  SPREAD_MIN_COUNT = 6'd3;

	// Configuration register map
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_WINDOW_LENGTH = 3'd0;
	localparam logic [COUNT_W-1:0] WINDOW_LENGTH_RESET = 6'd32;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DIV_MEAN,
		ST_MUL_SQ,
		ST_MUL_COUNT,
		ST_MUL_SUM,
		ST_SPREAD_LOAD,
		ST_DIV_SPREAD,
		ST_FINISH
	} state_t;

	// Operand selection of the shared multiplier outside the window walk
	typedef enum logic [1:0] {
		MUL_MEAN_SQ,
		MUL_COUNT,
		MUL_SUM
	} mul_sel_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic     accept;
		logic     walk_issue;
		logic     div_load_mean;
		logic     div_load_spread;
		logic     div_step;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     cap_mean;
		logic     cap_nmm;
		logic     out_load;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic walk_last;
		logic pipe_busy;
		logic div_last;
		logic few;
	} stat_t;

endpackage

// ----- design/wad_ram.sv -----
// Generic simple dual-port RAM with registered read.
module wad_ram #(
	parameter int WIDTH  = 12,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/wad_ctrl.sv -----
// Sequencer for window walk, mean and spread divisions, and result beat.
module wad_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  wad_pkg::stat_t stat,
	output wad_pkg::cmd_t  cmd
);

	wad_pkg::state_t state_q, state_d;
	logic out_valid_q;

	// State register and output beat flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wad_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wad_pkg::ST_IDLE: begin
				if (in_valid) state_d = wad_pkg::ST_WALK;
			end
			wad_pkg::ST_WALK: begin
				if (stat.walk_last) state_d = wad_pkg::ST_DRAIN;
			end
			wad_pkg::ST_DRAIN: begin
				if (!stat.pipe_busy) state_d = wad_pkg::ST_DIV_MEAN;
			end
			wad_pkg::ST_DIV_MEAN: begin
				if (stat.div_last) state_d = wad_pkg::ST_MUL_SQ;
			end
			wad_pkg::ST_MUL_SQ: begin
				state_d = stat.few ? wad_pkg::ST_FINISH : wad_pkg::ST_MUL_COUNT;
			end
			wad_pkg::ST_MUL_COUNT:   state_d = wad_pkg::ST_MUL_SUM;
			wad_pkg::ST_MUL_SUM:     state_d = wad_pkg::ST_SPREAD_LOAD;
			wad_pkg::ST_SPREAD_LOAD: state_d = wad_pkg::ST_DIV_SPREAD;
			wad_pkg::ST_DIV_SPREAD: begin
				if (stat.div_last) state_d = wad_pkg::ST_FINISH;
			end
			wad_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) state_d = wad_pkg::ST_IDLE;
			end
			default: state_d = wad_pkg::ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		cmd.mul_sel = wad_pkg::MUL_MEAN_SQ;
		unique case (state_q)
			wad_pkg::ST_IDLE:        cmd.accept = in_valid;
			wad_pkg::ST_WALK:        cmd.walk_issue = 1'b1;
			wad_pkg::ST_DRAIN:       cmd.div_load_mean = !stat.pipe_busy;
			wad_pkg::ST_DIV_MEAN:    cmd.div_step = 1'b1;
			wad_pkg::ST_MUL_SQ: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = wad_pkg::MUL_MEAN_SQ;
				cmd.cap_mean = 1'b1;
			end
			wad_pkg::ST_MUL_COUNT: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = wad_pkg::MUL_COUNT;
			end
			wad_pkg::ST_MUL_SUM: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = wad_pkg::MUL_SUM;
				cmd.cap_nmm = 1'b1;
			end
			wad_pkg::ST_SPREAD_LOAD: cmd.div_load_spread = 1'b1;
			wad_pkg::ST_DIV_SPREAD:  cmd.div_step = 1'b1;
			wad_pkg::ST_FINISH:      cmd.out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign in_ready  = (state_q == wad_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- design/wad_dp.sv -----
// Datapath: window ring, sum and square accumulation, multiplier, divider.
module wad_dp #(
	parameter int WINDOW_DEPTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wad_pkg::cmd_t                   cmd,
	output wad_pkg::stat_t                  stat,
	input  logic                            cfg_clear,
	input  logic [wad_pkg::COUNT_W-1:0]     window_length,
	input  logic [wad_pkg::SAMPLE_W-1:0]    sample,
	output logic [wad_pkg::SAMPLE_W-1:0]    mean,
	output logic [wad_pkg::SPREAD_W-1:0]    spread,
	output logic [wad_pkg::COUNT_W-1:0]     held_count
);

	localparam int AW      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int EFF_MAX = (WINDOW_DEPTH < 63) ? WINDOW_DEPTH : 63;
	localparam logic [wad_pkg::COUNT_W-1:0] LEN_MAX = 6'(EFF_MAX);

	localparam int CW = wad_pkg::COUNT_W;
	localparam int SW = wad_pkg::SAMPLE_W;

	// Window bookkeeping
	logic [CW-1:0] fill_q, oldest_q, n_q, idx_q;
	logic [CW-1:0] len, slot, slot_nxt, waddr_full;
	logic [7:0]    waddr_ext, raddr_ext;
	logic [AW-1:0] waddr, raddr;
	logic [SW-1:0] rdata;

	// Walk pipeline and accumulators
	logic                          vld_s1, vld_s2;
	logic [wad_pkg::SUM_W-1:0]     sum_q;
	logic [wad_pkg::ACC_W-1:0]     sumsq_q, prod_q, nmm_q;
	logic [SW-1:0]                 mean_q;

	// Multiplier
	logic [wad_pkg::MUL_A_W-1:0]   mul_a;
	logic [wad_pkg::MUL_B_W-1:0]   mul_b;
	logic [wad_pkg::MUL_A_W+wad_pkg::MUL_B_W-1:0] mul_p;

	// Divider
	logic [wad_pkg::DIV_W-1:0]     quo_q, quo_d;
	logic [wad_pkg::REM_W-1:0]     rem_q, rem_d;
	logic [wad_pkg::DCNT_W-1:0]    dcnt_q;
	logic [CW-1:0]                 half;
	logic [wad_pkg::SUM_W-1:0]     mean_dividend;
	logic [31:0]                   spread_sum;
	logic [wad_pkg::ACC_W-1:0]     spread_dividend;

	// Effective window length: zero acts as one, clamp to store depth
	always_comb begin
		if (window_length == '0) begin
			len = 6'd1;
		end else if (window_length > LEN_MAX) begin
			len = LEN_MAX;
		end else begin
			len = window_length;
		end
	end

	// Slot the new sample goes to once the window is full
	always_comb begin
		slot     = (oldest_q >= len) ? '0 : oldest_q;
		slot_nxt = slot + 6'd1;
		if (slot_nxt >= len) slot_nxt = '0;
		waddr_full = (fill_q < len) ? fill_q : slot;
	end

	assign waddr_ext = {2'b00, waddr_full};
	assign raddr_ext = {2'b00, idx_q};
	assign waddr     = waddr_ext[AW-1:0];
	assign raddr     = raddr_ext[AW-1:0];

	wad_ram #(
		.WIDTH (SW),
		.DEPTH (WINDOW_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.accept),
		.waddr (waddr),
		.wdata (sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Control state: fill level, oldest slot, walk index and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			oldest_q <= '0;
			n_q      <= '0;
			idx_q    <= '0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			dcnt_q   <= '0;
		end else begin
			if (cfg_clear) begin
				fill_q   <= '0;
				oldest_q <= '0;
			end else if (cmd.accept) begin
				if (fill_q < len) begin
					fill_q <= fill_q + 6'd1;
					n_q    <= fill_q + 6'd1;
				end else begin
					oldest_q <= slot_nxt;
					n_q      <= fill_q;
				end
			end
			if (cmd.accept) begin
				idx_q <= '0;
			end else if (cmd.walk_issue) begin
				idx_q <= idx_q + 6'd1;
			end
			vld_s1 <= cmd.walk_issue;
			vld_s2 <= vld_s1;
			if (cmd.div_load_mean) begin
				dcnt_q <= wad_pkg::MEAN_DIV_CYCLES;
			end else if (cmd.div_load_spread) begin
				dcnt_q <= wad_pkg::SPREAD_DIV_CYCLES;
			end else if (cmd.div_step && dcnt_q != '0) begin
				dcnt_q <= dcnt_q - 4'd1;
			end
		end
	end

	// Shared multiplier operands: sample square during the walk, else chosen by mul_sel
	always_comb begin
		if (vld_s1) begin
			mul_a = {12'd0, rdata};
			mul_b = rdata;
		end else begin
			unique case (cmd.mul_sel)
				wad_pkg::MUL_MEAN_SQ: begin
					mul_a = {12'd0, quo_q[SW-1:0]};
					mul_b = quo_q[SW-1:0];
				end
				wad_pkg::MUL_COUNT: begin
					mul_a = prod_q[wad_pkg::MUL_A_W-1:0];
					mul_b = {6'd0, n_q};
				end
				wad_pkg::MUL_SUM: begin
					mul_a = {6'd0, sum_q};
					mul_b = mean_q;
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	assign mul_p = mul_a * mul_b;

	// Divider: two restoring steps per cycle, divisor is the count
	always_comb begin
		quo_d = quo_q;
		rem_d = rem_q;
		for (int k = 0; k < wad_pkg::DIV_RADIX_STEPS; k++) begin
			rem_d = {rem_d[wad_pkg::REM_W-2:0], quo_d[wad_pkg::DIV_W-1]};
			quo_d = {quo_d[wad_pkg::DIV_W-2:0], 1'b0};
			if (rem_d >= {1'b0, n_q}) begin
				rem_d    = rem_d - {1'b0, n_q};
				quo_d[0] = 1'b1;
			end
		end
	end

	// Dividends with rounding term: sum((x-m)^2) = sumsq + n*m*m - 2*m*sum
	assign half            = n_q >> 1;
	assign mean_dividend   = sum_q + {12'd0, half};
	assign spread_sum      = {2'b00, sumsq_q} + {2'b00, nmm_q}
	                       - {1'b0, prod_q, 1'b0} + {26'd0, half};
	assign spread_dividend = spread_sum[wad_pkg::ACC_W-1:0];

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sum_q   <= '0;
			sumsq_q <= '0;
		end else begin
			if (vld_s1) sum_q <= sum_q + {6'd0, rdata};
			if (vld_s2) sumsq_q <= sumsq_q + prod_q;
		end
		if (vld_s1 || cmd.mul_en) begin
			prod_q <= mul_p[wad_pkg::ACC_W-1:0];
		end
		if (cmd.cap_mean) mean_q <= quo_q[SW-1:0];
		if (cmd.cap_nmm)  nmm_q  <= prod_q;
		if (cmd.div_load_mean) begin
			quo_q <= {mean_dividend, 14'd0};
			rem_q <= '0;
		end else if (cmd.div_load_spread) begin
			quo_q <= {spread_dividend, 2'd0};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
		if (cmd.out_load) begin
			mean       <= mean_q;
			spread     <= stat.few ? wad_pkg::SPREAD_FEW : quo_q[wad_pkg::SPREAD_W-1:0];
			held_count <= n_q;
		end
	end

	// Status
	assign stat.walk_last = (idx_q == n_q - 6'd1);
	assign stat.pipe_busy = vld_s1 | vld_s2;
	assign stat.div_last  = (dcnt_q == 4'd1);
	assign stat.few       = (n_q < wad_pkg::SPREAD_MIN_COUNT);

endmodule

// ----- design/window_average_dispersion.sv -----
// Top level: sliding-window mean and spread of 12-bit samples.
//
//   channel  signals                                         direction
//   ------   ----------------------------------------------  ---------
//   cfg      psel penable pwrite paddr pwdata prdata pready  in/out
//   in       in_valid in_ready sample                        in
//   out      out_valid out_ready mean spread held_count      out
//
// A beat runs through these steps in order, n being the samples held: walk reads
// of the n samples, drain, mean division at two quotient bits a cycle, products
// and spread load, spread division. Under three samples only the mean square is formed.
// in_ready returns the cycle after the result is loaded.
// A result waiting unread lets the next sample in, but stalls the one after.
// Reset empties the window and sets the window length to 32.
module window_average_dispersion #(
	parameter int WINDOW_DEPTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wad_pkg::PADDR_W-1:0]     paddr,
	input  logic [wad_pkg::PDATA_W-1:0]     pwdata,
	output logic [wad_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [wad_pkg::SAMPLE_W-1:0]    sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [wad_pkg::SAMPLE_W-1:0]    mean,
	output logic [wad_pkg::SPREAD_W-1:0]    spread,
	output logic [wad_pkg::COUNT_W-1:0]     held_count
);

	logic [wad_pkg::COUNT_W-1:0] window_length_q;
	logic                        wl_write;
	wad_pkg::cmd_t               cmd;
	wad_pkg::stat_t              stat;

	// Register write: a write to the window length register empties the window
	assign wl_write = psel && penable && pwrite && (paddr == wad_pkg::ADDR_WINDOW_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= wad_pkg::WINDOW_LENGTH_RESET;
		end else if (wl_write) begin
			window_length_q <= pwdata[wad_pkg::COUNT_W-1:0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (paddr == wad_pkg::ADDR_WINDOW_LENGTH) begin
			prdata[wad_pkg::COUNT_W-1:0] = window_length_q;
		end
	end

	assign pready = 1'b1;

	wad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	wad_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_clear     (wl_write),
		.window_length (window_length_q),
		.sample        (sample),
		.mean          (mean),
		.spread        (spread),
		.held_count    (held_count)
	);

endmodule

// ----- design/wad_checker.sv -----
// Port-level checks for the window average block, bound to the top level.
module wad_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [wad_pkg::PADDR_W-1:0]     paddr,
	input logic [wad_pkg::PDATA_W-1:0]     pwdata,
	input logic [wad_pkg::PDATA_W-1:0]     prdata,
	input logic                            pready,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [wad_pkg::SAMPLE_W-1:0]    sample,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [wad_pkg::SAMPLE_W-1:0]    mean,
	input logic [wad_pkg::SPREAD_W-1:0]    spread,
	input logic [wad_pkg::COUNT_W-1:0]     held_count
);

	// A result beat is held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped before it was taken");

	// One sample at a time: no beat taken in the cycle after one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a sample is still being worked");

	// A result always holds at least one sample
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> held_count != '0)
		else $error("result reports an empty window");

	// Spread is the fixed value while fewer than three samples are held
	a_few_spread: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (held_count < wad_pkg::SPREAD_MIN_COUNT)
		|-> spread == wad_pkg::SPREAD_FEW)
		else $error("spread wrong for a nearly empty window");

endmodule

bind window_average_dispersion wad_checker u_wad_checker (.*);
